// ----- design/lcgs_pkg.sv -----
// constants, types and count helpers for the lda collapsed gibbs sampler
// used by lda_collapsed_gibbs_sampler_top
package lcgs_pkg;

  localparam int MAX_TOPICS  = 16;
  localparam int TOPIC_W     = $clog2(MAX_TOPICS);
  localparam int MAX_VOCAB   = 1024;
  localparam int VOCAB_W     = $clog2(MAX_VOCAB);
  localparam int MAX_DOCS    = 256;
  localparam int DOC_W       = $clog2(MAX_DOCS);
  localparam int COUNT_W     = 24;
  localparam int RAND_W      = 16;
  localparam int WEIGHT_W    = 48;
  localparam int TW_ADDR_W   = TOPIC_W + VOCAB_W;
  localparam int DT_ADDR_W   = DOC_W + TOPIC_W;
  localparam int TW_DEPTH    = MAX_TOPICS * MAX_VOCAB;
  localparam int DT_DEPTH    = MAX_DOCS * MAX_TOPICS;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOPICS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOCAB  = 2'd3;

  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_RESAMPLE = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [14:0] {
    S_CLEAR = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_RDU   = 15'b000000000000100,
    S_UPD   = 15'b000000000001000,
    S_RDK   = 15'b000000000010000,
    S_LOAD  = 15'b000000000100000,
    S_MUL0  = 15'b000000001000000,
    S_MUL1  = 15'b000000010000000,
    S_DCHK  = 15'b000000100000000,
    S_DIV   = 15'b000001000000000,
    S_ACC   = 15'b000010000000000,
    S_THR0  = 15'b000100000000000,
    S_THR1  = 15'b001000000000000,
    S_SRCH  = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_t;

  // saturating increment or floor-at-zero decrement
  function automatic logic [COUNT_W-1:0] count_step(input logic [COUNT_W-1:0] c,
                                                    input logic inc);
    logic [COUNT_W-1:0] res;
    res = c;
    if (inc) begin
      if (c != COUNT_MAX) res = c + COUNT_W'(1);
    end else begin
      if (c != '0) res = c - COUNT_W'(1);
    end
    return res;
  endfunction

endpackage

// ----- design/lda_collapsed_gibbs_sampler_top.sv -----
// lda collapsed gibbs sampler: count stores, weight unit and topic search
// depends on lcgs_pkg
//
// usage:
//   in_* channel (valid/ready) carries one token: opcode, doc, word, old topic
//   and a 16-bit uniform fraction. out_* channel returns the topic now
//   assigned to the token, one result per input transfer.
//   cfg_* channel writes alpha, beta, topics in use and vocab size; it is
//   always ready and must only be used while the block is idle.
// sequence:
//   add token: the counts of the given topic are read and incremented.
//   resample: the old topic's counts are decremented, then each of the K active
//   topics takes a memory read, two multiplier passes and the bit-serial
//   divider, which sets the rate. one item is in flight at a time.
// reset:
//   rst_n is synchronous, active low. after reset the block sweeps both
//   count memories to zero, one entry a cycle, over 16384 addresses; in_ready
//   stays low during the sweep.
// stall:
//   the result waits in an output register while out_ready is low; the
//   next item may be accepted meanwhile but holds before its own result.
module lda_collapsed_gibbs_sampler_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_opcode,
  input  logic [lcgs_pkg::DOC_W-1:0]         in_doc_index,
  input  logic [lcgs_pkg::VOCAB_W-1:0]       in_word_index,
  input  logic [lcgs_pkg::TOPIC_W-1:0]       in_old_topic,
  input  logic [lcgs_pkg::RAND_W-1:0]        in_random_fraction,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lcgs_pkg::TOPIC_W-1:0]       out_new_topic,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lcgs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lcgs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int TW = lcgs_pkg::TOPIC_W;
  localparam int CW = lcgs_pkg::COUNT_W;
  localparam int WW = lcgs_pkg::WEIGHT_W;

  lcgs_pkg::state_t state_r, state_nxt;

  // configuration
  logic [15:0] alpha_r, beta_r;
  logic [4:0]  topics_r;
  logic [10:0] vocab_r;
  logic [26:0] vbeta_r;
  logic [TW-1:0] kact_m1;

  // token
  logic [lcgs_pkg::DOC_W-1:0]   doc_r;
  logic [lcgs_pkg::VOCAB_W-1:0] word_r;
  logic [lcgs_pkg::RAND_W-1:0]  rand_r;
  logic [TW-1:0] upd_topic_r, k_r, tok_topic;
  logic          upd_inc_r;

  // stores
  logic [CW-1:0] tw_mem [lcgs_pkg::TW_DEPTH];
  logic [CW-1:0] dt_mem [lcgs_pkg::DT_DEPTH];
  logic [CW-1:0] tt_r   [lcgs_pkg::MAX_TOPICS];
  logic [WW-1:0] cw_r   [lcgs_pkg::MAX_TOPICS];
  logic [CW-1:0] tw_rd_r, dt_rd_r;
  logic [lcgs_pkg::TW_ADDR_W-1:0] clr_cnt_r, tw_raddr, tw_waddr;
  logic [lcgs_pkg::DT_ADDR_W-1:0] dt_raddr, dt_waddr;
  logic [CW-1:0] tw_wdata, dt_wdata;
  logic          mem_we;
  logic [TW-1:0] topic_sel;

  // arithmetic
  logic [32:0] a_r, b_r, dn_r, rem_r;
  logic [65:0] acc_r;
  logic [WW-1:0] num_r, total_r;
  logic [5:0]  div_cnt_r;
  logic [32:0] mul_a;
  logic [16:0] mul_b;
  logic [49:0] mul_p;
  logic [33:0] div_rs, div_diff;
  logic        div_ge;
  logic [WW:0] acc_sum;
  logic [32:0] dn_calc;
  logic [WW-1:0] thr_u;

  logic out_valid_r;
  logic [TW-1:0] out_topic_r;

  assign in_ready      = (state_r == lcgs_pkg::S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_new_topic = out_topic_r;

  always_comb begin
    if (topics_r == 5'd0) kact_m1 = '0;
    else if (topics_r > 5'(lcgs_pkg::MAX_TOPICS)) kact_m1 = '1;
    else kact_m1 = TW'(topics_r - 5'd1);
  end

  assign tok_topic = (in_old_topic > kact_m1) ? kact_m1 : in_old_topic;

  // shared multiplier and divider step
  always_comb begin
    mul_a = a_r;
    mul_b = b_r[16:0];
    case (state_r)
      lcgs_pkg::S_MUL1: mul_b = {1'b0, b_r[32:17]};
      lcgs_pkg::S_THR0: begin
        mul_a = {9'b0, total_r[23:0]};
        mul_b = {1'b0, rand_r};
      end
      lcgs_pkg::S_THR1: begin
        mul_a = {9'b0, total_r[47:24]};
        mul_b = {1'b0, rand_r};
      end
      default: ;
    endcase
  end
  assign mul_p    = {17'b0, mul_a} * {33'b0, mul_b};
  assign div_rs   = {rem_r, num_r[WW-1]};
  assign div_ge   = div_rs >= {1'b0, dn_r};
  assign div_diff = div_rs - {1'b0, dn_r};
  assign acc_sum  = {1'b0, total_r} + {1'b0, num_r};
  assign thr_u    = acc_r[63:16];
  assign dn_calc  = {1'b0, tt_r[k_r], 8'b0} + {6'b0, vbeta_r};

  // memory ports
  assign topic_sel = (state_r == lcgs_pkg::S_RDU) ? upd_topic_r : k_r;
  assign tw_raddr  = {topic_sel, word_r};
  assign dt_raddr  = {doc_r, topic_sel};
  always_comb begin
    mem_we   = 1'b0;
    tw_waddr = {upd_topic_r, word_r};
    dt_waddr = {doc_r, upd_topic_r};
    tw_wdata = lcgs_pkg::count_step(tw_rd_r, upd_inc_r);
    dt_wdata = lcgs_pkg::count_step(dt_rd_r, upd_inc_r);
    case (state_r)
      lcgs_pkg::S_CLEAR: begin
        mem_we   = 1'b1;
        tw_waddr = clr_cnt_r;
        dt_waddr = clr_cnt_r[lcgs_pkg::DT_ADDR_W-1:0];
        tw_wdata = '0;
        dt_wdata = '0;
      end
      lcgs_pkg::S_UPD: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tw_mem[tw_waddr] <= tw_wdata;
      dt_mem[dt_waddr] <= dt_wdata;
    end
    tw_rd_r <= tw_mem[tw_raddr];
    dt_rd_r <= dt_mem[dt_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lcgs_pkg::MAX_TOPICS; i++) tt_r[i] <= '0;
    end else if (state_r == lcgs_pkg::S_UPD) begin
      tt_r[upd_topic_r] <= lcgs_pkg::count_step(tt_r[upd_topic_r], upd_inc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == lcgs_pkg::S_ACC) begin
      cw_r[k_r] <= acc_sum[WW] ? {WW{1'b1}} : acc_sum[WW-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lcgs_pkg::S_CLEAR: if (&clr_cnt_r) state_nxt = lcgs_pkg::S_IDLE;
      lcgs_pkg::S_IDLE:  if (in_valid) state_nxt = lcgs_pkg::S_RDU;
      lcgs_pkg::S_RDU:   state_nxt = lcgs_pkg::S_UPD;
      lcgs_pkg::S_UPD:   state_nxt = upd_inc_r ? lcgs_pkg::S_DONE : lcgs_pkg::S_RDK;
      lcgs_pkg::S_RDK:   state_nxt = lcgs_pkg::S_LOAD;
      lcgs_pkg::S_LOAD:  state_nxt = lcgs_pkg::S_MUL0;
      lcgs_pkg::S_MUL0:  state_nxt = lcgs_pkg::S_MUL1;
      lcgs_pkg::S_MUL1:  state_nxt = lcgs_pkg::S_DCHK;
      lcgs_pkg::S_DCHK:
        state_nxt = ({7'b0, acc_r[65:40]} >= dn_r) ? lcgs_pkg::S_ACC : lcgs_pkg::S_DIV;
      lcgs_pkg::S_DIV:   if (div_cnt_r == 6'(WW - 1)) state_nxt = lcgs_pkg::S_ACC;
      lcgs_pkg::S_ACC:   state_nxt = (k_r == kact_m1) ? lcgs_pkg::S_THR0 : lcgs_pkg::S_RDK;
      lcgs_pkg::S_THR0:  state_nxt = lcgs_pkg::S_THR1;
      lcgs_pkg::S_THR1:  state_nxt = lcgs_pkg::S_SRCH;
      lcgs_pkg::S_SRCH:
        if (thr_u < cw_r[k_r] || k_r == kact_m1) state_nxt = lcgs_pkg::S_RDU;
      lcgs_pkg::S_DONE:  if (!out_valid_r || out_ready) state_nxt = lcgs_pkg::S_IDLE;
      default:           state_nxt = lcgs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcgs_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      alpha_r     <= 16'd256;
      beta_r      <= 16'd26;
      topics_r    <= 5'd16;
      vocab_r     <= 11'd1024;
    end else begin
      state_r <= state_nxt;
      if (state_r == lcgs_pkg::S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cfg_valid) begin
        case (cfg_index)
          lcgs_pkg::REG_ALPHA:  alpha_r  <= cfg_data;
          lcgs_pkg::REG_BETA:   beta_r   <= cfg_data;
          lcgs_pkg::REG_TOPICS: topics_r <= cfg_data[4:0];
          lcgs_pkg::REG_VOCAB:  vocab_r  <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (state_r == lcgs_pkg::S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    vbeta_r <= 27'(vocab_r * beta_r);
    case (state_r)
      lcgs_pkg::S_IDLE: begin
        doc_r       <= in_doc_index;
        word_r      <= in_word_index;
        rand_r      <= in_random_fraction;
        upd_topic_r <= tok_topic;
        upd_inc_r   <= (in_opcode == lcgs_pkg::OP_ADD);
        total_r     <= '0;
      end
      lcgs_pkg::S_UPD: k_r <= '0;
      lcgs_pkg::S_LOAD: begin
        a_r  <= {1'b0, tw_rd_r, 8'b0} + {17'b0, beta_r};
        b_r  <= {1'b0, dt_rd_r, 8'b0} + {17'b0, alpha_r};
        dn_r <= (dn_calc == '0) ? 33'd1 : dn_calc;
      end
      lcgs_pkg::S_MUL0, lcgs_pkg::S_THR0: acc_r <= {16'b0, mul_p};
      lcgs_pkg::S_MUL1: acc_r <= acc_r + ({16'b0, mul_p} << 17);
      lcgs_pkg::S_THR1: begin
        acc_r <= acc_r + ({16'b0, mul_p} << 24);
        k_r   <= '0;
      end
      lcgs_pkg::S_DCHK: begin
        // quotient of 2^48 or more saturates
        if ({7'b0, acc_r[65:40]} >= dn_r) begin
          num_r <= '1;
        end else begin
          rem_r     <= {7'b0, acc_r[65:40]};
          num_r     <= {acc_r[39:0], 8'b0};
          div_cnt_r <= '0;
        end
      end
      lcgs_pkg::S_DIV: begin
        rem_r     <= div_ge ? div_diff[32:0] : div_rs[32:0];
        num_r     <= {num_r[WW-2:0], div_ge};
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      lcgs_pkg::S_ACC: begin
        total_r <= acc_sum[WW] ? {WW{1'b1}} : acc_sum[WW-1:0];
        if (k_r != kact_m1) k_r <= k_r + 1'b1;
      end
      lcgs_pkg::S_SRCH: begin
        if (thr_u < cw_r[k_r] || k_r == kact_m1) begin
          upd_topic_r <= k_r;
          upd_inc_r   <= 1'b1;
        end else begin
          k_r <= k_r + 1'b1;
        end
      end
      lcgs_pkg::S_DONE:
        if (!out_valid_r || out_ready) out_topic_r <= upd_topic_r;
      default: ;
    endcase
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_no_input_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lcgs_pkg::S_CLEAR |-> !in_ready)
    else $error("input ready during clearing sweep");

  a_search_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lcgs_pkg::S_SRCH |-> k_r <= kact_m1)
    else $error("search ran past active topics");

  a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_topic_r <= kact_m1)
    else $error("result topic out of range");

endmodule
